// ===== rtl/lis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// List item splitter package
// Types, character codes and small helper functions for the list splitter.
// ----------------------------------------------------------------------------
package lis_pkg;

  typedef enum logic [1:0] {
    MODE_GAP   = 2'd0,
    MODE_BRACE = 2'd1,
    MODE_QUOTE = 2'd2,
    MODE_BARE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BRACE = 2'd1,
    ST_QUOTE = 2'd2,
    ST_NEST  = 2'd3
  } status_e;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] item_char;
    logic       item_done;
    status_e    status;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CH_LOW_N) begin
      r = CH_NL;
    end else if (c == CH_LOW_T) begin
      r = CH_TAB;
    end
    return r;
  endfunction

endpackage

// ===== rtl/lis_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// List splitter parse core
// Holds the parse state and works out the result for one text byte.
// ----------------------------------------------------------------------------
module lis_core import lis_pkg::*; #(
  parameter int MAX_NEST = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output result_t    res_o
);

  localparam int DepthW = $clog2(MAX_NEST + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_NEST);
  localparam logic [DepthW-1:0] DepthOne = DepthW'(1);

  mode_e             mode_q, mode_d, eff_mode;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              esc_q, esc_d;
  result_t           res;
  logic [7:0]        c;

  assign c = in_byte_i;

  always_comb begin
    eff_mode = mode_q;
    if (mode_q == MODE_GAP && !is_blank(c) && c != CH_LBRACE && c != CH_QUOTE) begin
      eff_mode = MODE_BARE;
    end
  end

  always_comb begin
    mode_d         = eff_mode;
    depth_d        = depth_q;
    esc_d          = esc_q;
    res.char_valid = 1'b0;
    res.item_char  = 8'h00;
    res.item_done  = 1'b0;
    res.status     = ST_OK;
    case (eff_mode)
      MODE_GAP: begin
        if (c == CH_LBRACE) begin
          mode_d  = MODE_BRACE;
          depth_d = DepthOne;
          if (last_byte_i) begin
            res.status = ST_BRACE;
          end
        end else if (c == CH_QUOTE) begin
          mode_d = MODE_QUOTE;
          if (last_byte_i) begin
            res.status = ST_QUOTE;
          end
        end
      end
      MODE_BARE: begin
        if (esc_q) begin
          esc_d          = 1'b0;
          res.char_valid = 1'b1;
          res.item_char  = unescape(c);
        end else if (is_blank(c)) begin
          res.item_done = 1'b1;
          mode_d        = MODE_GAP;
        end else if (c == CH_BSLASH && !last_byte_i) begin
          esc_d = 1'b1;
        end else begin
          res.char_valid = 1'b1;
          res.item_char  = c;
        end
        if (last_byte_i) begin
          res.item_done = 1'b1;
        end
      end
      MODE_QUOTE: begin
        if (esc_q) begin
          esc_d          = 1'b0;
          res.char_valid = 1'b1;
          res.item_char  = unescape(c);
        end else if (c == CH_QUOTE) begin
          res.item_done = 1'b1;
          mode_d        = MODE_GAP;
        end else if (c == CH_BSLASH && !last_byte_i) begin
          esc_d = 1'b1;
        end else begin
          res.char_valid = 1'b1;
          res.item_char  = c;
        end
        if (last_byte_i && mode_d == MODE_QUOTE) begin
          res.status = ST_QUOTE;
        end
      end
      MODE_BRACE: begin
        if (esc_q) begin
          esc_d          = 1'b0;
          res.char_valid = 1'b1;
          res.item_char  = c;
        end else if (c == CH_BSLASH) begin
          res.char_valid = 1'b1;
          res.item_char  = c;
          esc_d          = !last_byte_i;
        end else if (c == CH_LBRACE) begin
          if (depth_q >= DepthMax) begin
            res.status = ST_NEST;
            mode_d     = MODE_GAP;
            depth_d    = '0;
            esc_d      = 1'b0;
          end else begin
            depth_d        = depth_q + DepthOne;
            res.char_valid = 1'b1;
            res.item_char  = c;
          end
        end else if (c == CH_RBRACE) begin
          if (depth_q <= DepthOne) begin
            depth_d       = '0;
            res.item_done = 1'b1;
            mode_d        = MODE_GAP;
          end else begin
            depth_d        = depth_q - DepthOne;
            res.char_valid = 1'b1;
            res.item_char  = c;
          end
        end else begin
          res.char_valid = 1'b1;
          res.item_char  = c;
        end
        if (last_byte_i && mode_d == MODE_BRACE) begin
          res.status = ST_BRACE;
        end
      end
      default: begin
        mode_d = MODE_GAP;
      end
    endcase
    if (res.status != ST_OK) begin
      res.char_valid = 1'b0;
      res.item_char  = 8'h00;
      res.item_done  = 1'b0;
    end
    if (last_byte_i) begin
      mode_d  = MODE_GAP;
      depth_d = '0;
      esc_d   = 1'b0;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_GAP;
      depth_q <= '0;
      esc_q   <= 1'b0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      esc_q   <= esc_d;
    end
  end

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_byte_i |=> mode_q == MODE_GAP && depth_q == '0 && !esc_q)
    else $error("State not cleared after the final byte of a text.");

  a_depth_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_BRACE) == (depth_q != '0))
    else $error("Brace depth disagrees with the parse mode.");

  a_esc_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> mode_q != MODE_GAP)
    else $error("Escape pending between items.");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthMax)
    else $error("Brace depth above the nesting bound.");

endmodule

// ===== rtl/list_item_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// List item splitter
// Splits list text into items one byte per transaction, with one result per
// byte. An input register feeds the parse core, whose result is registered.
// ----------------------------------------------------------------------------
// Channel | Handshake                 | Payload
// input   | in_valid_i / in_stall_o   | in_byte_i, last_byte_i
// output  | out_valid_o / out_stall_i | char_valid_o, item_char_o, item_done_o,
//         |                           | status_o
//
// One transaction per cycle is sustained while the output is not stalled; each
// result passes through the input register and then the result register before
// it appears on the output. The parse state is updated as a byte moves from the
// input register into the result register, so the next byte follows at once.
// Reset leaves the splitter between items with both registers empty.
// A stalled output holds its result and stalls the input only when both
// registers are full.
// ----------------------------------------------------------------------------
module list_item_splitter import lis_pkg::*; #(
  parameter int MAX_NEST = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       char_valid_o,
  output logic [7:0] item_char_o,
  output logic       item_done_o,
  output logic [1:0] status_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res;
  logic       out_ready;
  logic       fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  lis_core #(
    .MAX_NEST(MAX_NEST)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .in_byte_i  (byte_q),
    .last_byte_i(last_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= last_byte_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_valid_o = res_q.char_valid;
  assign item_char_o  = res_q.item_char;
  assign item_done_o  = res_q.item_done;
  assign status_o     = res_q.status;

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> !char_valid_o && !item_done_o
      && item_char_o == 8'h00)
    else $error("Error result carries a character or an item end.");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("Input stalled while the pipeline has room.");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(byte_q) && $stable(last_q))
    else $error("Held byte lost from the input register.");

endmodule

// ===== tb/sv/list_item_splitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// List item splitter testbench
// Feeds list texts one byte per transaction and checks every result against a
// cycle-free model of the splitter. A short table of directed bytes comes
// first, then two deep nesting texts and a run of random list texts.
// Both channels idle at random, except during a calm run of the random texts.
// ----------------------------------------------------------------------------
module list_item_splitter_tb import lis_pkg::*; ();

  localparam int NEST_LIMIT = 255;
  localparam int RAND_BYTES = 410;
  localparam int N_ROWS     = 29;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    res;
  } step_row_t;

  localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  localparam step_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{8'h20,     1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, ST_OK}},
    '{"a",       1'b0, 1'b0, '0},
    '{8'hFF,     1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, ST_OK}},
    '{8'h0B,     1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, ST_OK}},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_LOW_N,  1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_LOW_T,  1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{8'h20,     1'b0, 1'b0, '0},
    '{8'h00,     1'b1, 1'b0, '0},
    '{CH_QUOTE,  1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_QUOTE,  1'b0, 1'b0, '0},
    '{CH_QUOTE,  1'b0, 1'b0, '0},
    '{CH_LBRACE, 1'b0, 1'b0, '0},
    '{CH_LBRACE, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_RBRACE, 1'b0, 1'b0, '0},
    '{CH_RBRACE, 1'b0, 1'b0, '0},
    '{CH_RBRACE, 1'b1, 1'b0, '0},
    '{CH_LBRACE, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, ST_BRACE}},
    '{CH_QUOTE,  1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, ST_QUOTE}},
    '{CH_QUOTE,  1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, ST_QUOTE}},
    '{CH_BSLASH, 1'b1, 1'b1, '{1'b1, CH_BSLASH, 1'b1, ST_OK}},
    '{CH_LBRACE, 1'b0, 1'b0, '0},
    '{"z",       1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, ST_BRACE}},
    '{8'h0C,     1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, ST_OK}}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       char_valid_o;
  logic [7:0] item_char_o;
  logic       item_done_o;
  logic [1:0] status_o;

  list_item_splitter #(
    .MAX_NEST(NEST_LIMIT)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_byte_i,
    .last_byte_i,
    .out_valid_o,
    .out_stall_i,
    .char_valid_o,
    .item_char_o,
    .item_done_o,
    .status_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Model state of the splitter.
  mode_e split_mode = MODE_GAP;
  int    nest_depth = 0;
  logic  esc_held = 1'b0;

  step_row_t  sent_q[$];
  result_t    expected_q[$];
  logic [7:0] text_q[$];
  bit         calm = 1'b0;
  int         mismatches = 0;
  int         results_seen = 0;
  int         item_ends = 0;
  int         error_results = 0;
  int         texts_sent = 0;

  function automatic logic is_space_byte(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] expand_escape(input logic [7:0] c);
    if (c == CH_LOW_N) begin
      return CH_NL;
    end
    if (c == CH_LOW_T) begin
      return CH_TAB;
    end
    return c;
  endfunction

  function automatic result_t predict_split(input logic [7:0] c, input logic last);
    result_t r;
    logic    taken;
    r = '0;
    r.status = ST_OK;
    taken = 1'b0;
    if (split_mode == MODE_GAP) begin
      if (is_space_byte(c)) begin
        taken = 1'b1;
      end else if (c == CH_LBRACE) begin
        split_mode = MODE_BRACE;
        nest_depth = 1;
        taken = 1'b1;
        if (last) r.status = ST_BRACE;
      end else if (c == CH_QUOTE) begin
        split_mode = MODE_QUOTE;
        taken = 1'b1;
        if (last) r.status = ST_QUOTE;
      end else begin
        split_mode = MODE_BARE;
      end
    end
    if (!taken) begin
      case (split_mode)
        MODE_BARE: begin
          if (esc_held) begin
            esc_held = 1'b0;
            r.char_valid = 1'b1;
            r.item_char = expand_escape(c);
          end else if (is_space_byte(c)) begin
            r.item_done = 1'b1;
            split_mode = MODE_GAP;
          end else if (c == CH_BSLASH && !last) begin
            esc_held = 1'b1;
          end else begin
            r.char_valid = 1'b1;
            r.item_char = c;
          end
          if (last) r.item_done = 1'b1;
        end
        MODE_QUOTE: begin
          if (esc_held) begin
            esc_held = 1'b0;
            r.char_valid = 1'b1;
            r.item_char = expand_escape(c);
          end else if (c == CH_QUOTE) begin
            r.item_done = 1'b1;
            split_mode = MODE_GAP;
          end else if (c == CH_BSLASH && !last) begin
            esc_held = 1'b1;
          end else begin
            r.char_valid = 1'b1;
            r.item_char = c;
          end
          if (last && split_mode == MODE_QUOTE) r.status = ST_QUOTE;
        end
        MODE_BRACE: begin
          if (esc_held) begin
            esc_held = 1'b0;
            r.char_valid = 1'b1;
            r.item_char = c;
          end else if (c == CH_BSLASH) begin
            r.char_valid = 1'b1;
            r.item_char = c;
            esc_held = !last;
          end else if (c == CH_LBRACE) begin
            if (nest_depth >= NEST_LIMIT) begin
              r.status = ST_NEST;
              split_mode = MODE_GAP;
              nest_depth = 0;
              esc_held = 1'b0;
            end else begin
              nest_depth++;
              r.char_valid = 1'b1;
              r.item_char = c;
            end
          end else if (c == CH_RBRACE) begin
            if (nest_depth <= 1) begin
              nest_depth = 0;
              r.item_done = 1'b1;
              split_mode = MODE_GAP;
            end else begin
              nest_depth--;
              r.char_valid = 1'b1;
              r.item_char = c;
            end
          end else begin
            r.char_valid = 1'b1;
            r.item_char = c;
          end
          if (last && split_mode == MODE_BRACE) r.status = ST_BRACE;
        end
        default: ;
      endcase
    end
    if (r.status != ST_OK) begin
      r.char_valid = 1'b0;
      r.item_char = 8'h00;
      r.item_done = 1'b0;
    end
    if (last) begin
      split_mode = MODE_GAP;
      nest_depth = 0;
      esc_held = 1'b0;
    end
    return r;
  endfunction

  // Every accepted byte is predicted in order; a typed row overrides the model.
  always @(posedge clk_i) begin
    step_row_t row;
    result_t   pred;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pred = predict_split(in_byte_i, last_byte_i);
      row = sent_q.pop_front();
      expected_q.push_back(row.typed ? row.res : pred);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{char_valid_o, item_char_o, item_done_o, status_e'(status_o)};
      results_seen++;
      if (item_done_o) item_ends++;
      if (status_o != ST_OK) error_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result at %0t: valid=%0b char=%02h done=%0b status=%0d",
                   $time, char_valid_o, item_char_o, item_done_o, status_o);
        end
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: expected valid=%0b char=%02h done=%0b status=%0d",
                     $time, want.char_valid, want.item_char, want.item_done, want.status);
            $display("                 got valid=%0b char=%02h done=%0b status=%0d",
                     char_valid_o, item_char_o, item_done_o, status_o);
          end
        end
      end
    end
    out_stall_i <= rst_ni && !calm && ($urandom_range(99) < 16);
  end

  task automatic send_byte(input step_row_t row);
    sent_q.push_back(row);
    if (!calm) begin
      while ($urandom_range(99) < 16) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_byte_i <= row.data;
    last_byte_i <= row.last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte('{text_q[i], (i == text_q.size() - 1), 1'b0, '0});
    end
    texts_sent++;
  endtask

  function automatic logic [7:0] escape_partner();
    case ($urandom_range(2))
      0: return CH_LOW_N;
      1: return CH_LOW_T;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Builds one list text: mostly well-formed items with random content, with
  // some noise, truncated texts and trailing backslashes mixed in.
  task automatic compose_list_text();
    int         n_items;
    int         kind;
    int         len;
    int         depth;
    int         pick;
    logic [7:0] b;
    text_q.delete();
    n_items = $urandom_range(1, 5);
    for (int k = 0; k < n_items; k++) begin
      if ((k > 0 && $urandom_range(9) != 0) || $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 2)) text_q.push_back(BLANKS[$urandom_range(5)]);
      end
      kind = $urandom_range(99);
      if (kind < 30) begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(99) < 15) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(escape_partner());
          end else begin
            b = 8'($urandom_range(255));
            while (is_space_byte(b)) b = 8'($urandom_range(255));
            if (j == 0 && (b == CH_LBRACE || b == CH_QUOTE)) b = "a";
            text_q.push_back(b);
          end
        end
      end else if (kind < 55) begin
        text_q.push_back(CH_QUOTE);
        len = $urandom_range(0, 6);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(99) < 20) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(escape_partner());
          end else begin
            b = 8'($urandom_range(255));
            if (b == CH_QUOTE || b == CH_BSLASH) b = "q";
            text_q.push_back(b);
          end
        end
        text_q.push_back(CH_QUOTE);
      end else if (kind < 85) begin
        text_q.push_back(CH_LBRACE);
        depth = 1;
        len = $urandom_range(0, 8);
        for (int j = 0; j < len; j++) begin
          pick = $urandom_range(99);
          if (pick < 15 && depth < 6) begin
            text_q.push_back(CH_LBRACE);
            depth++;
          end else if (pick < 30 && depth > 1) begin
            text_q.push_back(CH_RBRACE);
            depth--;
          end else if (pick < 42) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(8'($urandom_range(255)));
          end else begin
            b = 8'($urandom_range(255));
            if (b == CH_LBRACE || b == CH_RBRACE || b == CH_BSLASH) b = "b";
            text_q.push_back(b);
          end
        end
        while (depth > 0) begin
          text_q.push_back(CH_RBRACE);
          depth--;
        end
      end else begin
        repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(99) < 10) text_q.push_back(BLANKS[$urandom_range(5)]);
    if ($urandom_range(99) < 6) text_q.push_back(CH_BSLASH);
    if ($urandom_range(99) < 8 && text_q.size() > 1) begin
      repeat ($urandom_range(1, text_q.size() - 1)) void'(text_q.pop_back());
    end
  endtask

  initial begin
    int rand_bytes;
    rand_bytes = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      send_byte(DIRECTED_ROWS[i]);
    end

    // One brace too many for the nesting bound, then a text that just fits.
    text_q.delete();
    repeat (NEST_LIMIT + 1) text_q.push_back(CH_LBRACE);
    text_q.push_back("k");
    send_text();
    text_q.delete();
    repeat (NEST_LIMIT) text_q.push_back(CH_LBRACE);
    text_q.push_back("x");
    repeat (NEST_LIMIT) text_q.push_back(CH_RBRACE);
    send_text();

    while (rand_bytes < RAND_BYTES) begin
      calm = (rand_bytes >= 120 && rand_bytes < 280);
      compose_list_text();
      rand_bytes += text_q.size();
      send_text();
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d texts plus %0d directed bytes; checked %0d results.",
             texts_sent, N_ROWS, results_seen);
    $display("Results held %0d item ends and %0d error statuses.", item_ends, error_results);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
